@@ design/nbu_pkg.sv @@
// Shared types, constants, tanh table and microcode ROM for the neuron backprop unit.
`default_nettype none

package nbu_pkg;

    localparam int MAX_INPUTS = 256;
    localparam int FRAC_BITS  = 12;
    localparam int TANH_DEPTH = 256;
    localparam int RATE_FRAC  = 12;
    localparam int IDX_W      = $clog2(MAX_INPUTS);
    localparam int TANH_IDX_W = $clog2(TANH_DEPTH);

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_FWD    = 3'd1;
    localparam logic [2:0] OP_OGRAD  = 3'd2;
    localparam logic [2:0] OP_HGRAD  = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic REG_RATE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic [12:0] RATE_RESET = 13'd614;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic        [7:0]  index;
        logic signed [15:0] value;
        logic signed [15:0] outgoing_weight;
        logic               last;
    } t_cmd_item;

    typedef struct packed {
        logic        [2:0]  kind;
        logic signed [15:0] result_value;
        logic               saturated;
    } t_result_item;

    // Multiplier operand selects
    localparam logic [2:0] MA_VAL  = 3'd0;
    localparam logic [2:0] MA_TMP  = 3'd1;
    localparam logic [2:0] MA_OUT  = 3'd2;
    localparam logic [2:0] MA_DIFF = 3'd3;
    localparam logic [2:0] MA_PROD = 3'd4;

    localparam logic [2:0] MB_WRD  = 3'd0;
    localparam logic [2:0] MB_OW   = 3'd1;
    localparam logic [2:0] MB_LEAK = 3'd2;
    localparam logic [2:0] MB_OUT  = 3'd3;
    localparam logic [2:0] MB_DER  = 3'd4;
    localparam logic [2:0] MB_GRAD = 3'd5;
    localparam logic [2:0] MB_RATE = 3'd6;

    localparam logic [2:0] EM_NONE  = 3'd0;
    localparam logic [2:0] EM_FWD   = 3'd1;
    localparam logic [2:0] EM_OGRAD = 3'd2;
    localparam logic [2:0] EM_HGRAD = 3'd3;
    localparam logic [2:0] EM_UPD   = 3'd4;

    localparam logic [1:0] JP_NEXT    = 2'd0;
    localparam logic [1:0] JP_DONE    = 2'd1;
    localparam logic [1:0] JP_DONE_NL = 2'd2;

    typedef struct packed {
        logic [2:0] mul_a;
        logic [2:0] mul_b;
        logic       mul_en;
        logic       acc_add;
        logic       acc_round;
        logic       der_load;
        logic       mem_wr;
        logic [2:0] emit;
        logic [1:0] jmp;
    } t_uword;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] PC_WRITE = 5'd0;
    localparam logic [PC_W-1:0] PC_FWD   = 5'd1;
    localparam logic [PC_W-1:0] PC_OGRAD = 5'd7;
    localparam logic [PC_W-1:0] PC_HGRAD = 5'd11;
    localparam logic [PC_W-1:0] PC_UPD   = 5'd17;

    localparam t_uword UW_NOP = '{mul_a: MA_VAL, mul_b: MB_WRD, mul_en: 1'b0,
                                  acc_add: 1'b0, acc_round: 1'b0, der_load: 1'b0,
                                  mem_wr: 1'b0, emit: EM_NONE, jmp: JP_DONE};

    function automatic t_uword uw(input logic [2:0] ma, input logic [2:0] mb,
                                  input logic mul, input logic add, input logic rnd,
                                  input logic der, input logic wr,
                                  input logic [2:0] em, input logic [1:0] jp);
        t_uword w;
        w.mul_a     = ma;
        w.mul_b     = mb;
        w.mul_en    = mul;
        w.acc_add   = add;
        w.acc_round = rnd;
        w.der_load  = der;
        w.mem_wr    = wr;
        w.emit      = em;
        w.jmp       = jp;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // write weight
            5'd0:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, EM_NONE,  JP_DONE);
            // forward element: wait for weight read, multiply, accumulate
            5'd1:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd2:  w = uw(MA_VAL,  MB_WRD,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd3:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_DONE_NL);
            5'd4:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd5:  w = uw(MA_TMP,  MB_LEAK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd6:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EM_FWD,   JP_DONE);
            // output gradient
            5'd7:  w = uw(MA_OUT,  MB_OUT,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd8:  w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EM_NONE,  JP_NEXT);
            5'd9:  w = uw(MA_DIFF, MB_DER,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd10: w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EM_OGRAD, JP_DONE);
            // hidden gradient element
            5'd11: w = uw(MA_VAL,  MB_OW,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd12: w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_DONE_NL);
            5'd13: w = uw(MA_OUT,  MB_OUT,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd14: w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EM_NONE,  JP_NEXT);
            5'd15: w = uw(MA_TMP,  MB_DER,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd16: w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EM_HGRAD, JP_DONE);
            // weight update
            5'd17: w = uw(MA_VAL,  MB_GRAD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd18: w = uw(MA_PROD, MB_RATE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE,  JP_NEXT);
            5'd19: w = uw(MA_VAL,  MB_WRD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EM_UPD,   JP_DONE);
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] op_entry(input logic [2:0] op);
        logic [PC_W-1:0] pc;
        case (op)
            OP_WRITE:  pc = PC_WRITE;
            OP_FWD:    pc = PC_FWD;
            OP_OGRAD:  pc = PC_OGRAD;
            OP_HGRAD:  pc = PC_HGRAD;
            OP_UPDATE: pc = PC_UPD;
            default:   pc = PC_WRITE;
        endcase
        return pc;
    endfunction

    // Elaboration-time table build: shift-subtract quotient
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam logic [63:0] Q30 = 64'd1 << 30;

    // tanh(4i/depth) via exp(-2x) from a Taylor series and four squarings
    function automatic logic [15:0] tanh_entry(input int i);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] den;
        z    = (64'(i) << 29) / TANH_DEPTH;
        term = Q30;
        sum  = Q30;
        for (int k = 1; k <= 14; k++) begin
            term = udiv64((term * z) >> 30, 64'(k));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 4; k++) begin
            sum = (sum * sum) >> 30;
        end
        num = (Q30 - sum) << (FRAC_BITS + 1);
        den = 64'd2 * (Q30 + sum);
        return 16'(udiv64(num + Q30 + sum, den));
    endfunction

    typedef logic [TANH_DEPTH-1:0][15:0] t_tanh_lut;

    function automatic t_tanh_lut build_tanh_lut();
        t_tanh_lut lut;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            lut[i] = tanh_entry(i);
        end
        return lut;
    endfunction

    localparam t_tanh_lut TANH_LUT = build_tanh_lut();

endpackage

`default_nettype wire

@@ design/nbu_seq.sv @@
// Microcode sequencer: step counter, control ROM fetch and opcode dispatch.
`default_nettype none

module nbu_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [2:0]    i_opcode,
    input  wire logic          i_last,
    output logic               o_busy,
    output nbu_pkg::t_uword    o_uword
);
    import nbu_pkg::*;

    logic            r_busy;
    logic            n_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;

    assign w_word = ucode(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            // unused opcodes are dropped without going busy
            if (i_start && i_opcode <= OP_UPDATE) begin
                n_busy = 1'b1;
                n_pc   = op_entry(i_opcode);
            end
        end else begin
            case (w_word.jmp)
                JP_NEXT: begin
                    n_pc = r_pc + 1'b1;
                end
                JP_DONE: begin
                    n_busy = 1'b0;
                end
                JP_DONE_NL: begin
                    if (i_last) begin
                        n_pc = r_pc + 1'b1;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy  = r_busy;
    assign o_uword = r_busy ? w_word : UW_NOP;

endmodule

`default_nettype wire

@@ design/neuron_backprop_unit.sv @@
// Top level of the neuron backprop unit: APB registers, weight memory and datapath.
`default_nettype none

// One neuron trained by backpropagation in saturating Q3.12. A command word is
// taken when start is high and busy is low; every command runs to completion
// before the next is taken. Forward and hidden gradient elements run longer on
// the last element. The microcode program runs on one shared 32x20 multiplier
// with a register after it, a weight memory with a registered read port, and
// one microcode step per cycle.
// A result word appears on o_result for exactly one cycle, flagged by
// o_result_valid, in the same cycle as busy falls; the receiver cannot stall it.
// Registers: learning_rate at byte address 0, activation_mode at 4.
module neuron_backprop_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire nbu_pkg::t_cmd_item    i_cmd,
    output logic                       o_result_valid,
    output nbu_pkg::t_result_item      o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import nbu_pkg::*;

    localparam int MUL_W  = 52;
    localparam int WIDE_W = MUL_W + 1;
    localparam int ACC_W  = 40;
    localparam int TMP_W  = ACC_W - FRAC_BITS + 1;
    localparam int DER_W  = 20;

    localparam logic signed [ACC_W:0]  ACC_MAX = (41'sd1 <<< (ACC_W - 1)) - 41'sd1;
    localparam logic signed [ACC_W:0]  ACC_MIN = -(41'sd1 <<< (ACC_W - 1));
    localparam logic signed [DER_W-1:0] ONE_Q  = DER_W'(1 << FRAC_BITS);
    localparam logic signed [DER_W-1:0] LEAK_Q = DER_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam int UPD_SHIFT = 2 * FRAC_BITS + RATE_FRAC;

    function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] x,
                                                      input int n);
        logic signed [WIDE_W-1:0] half;
        half = WIDE_W'(1) <<< (n - 1);
        return (x + half) >>> n;
    endfunction

    // {saturated, value}
    function automatic logic [16:0] sat16(input logic signed [WIDE_W-1:0] x);
        logic [16:0] r;
        if (x > WIDE_W'(32767)) begin
            r = {1'b1, 16'h7fff};
        end else if (x < -WIDE_W'(32768)) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, x[15:0]};
        end
        return r;
    endfunction

    t_uword                    w_uw;
    logic                      w_accept;
    logic                      w_cfg_wr;

    t_cmd_item                 r_cmd;
    logic [12:0]               r_rate;
    logic                      r_mode;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [15:0]        r_out;
    logic signed [15:0]        r_grad;
    logic signed [TMP_W-1:0]   r_tmp;
    logic signed [DER_W-1:0]   r_der;
    logic signed [MUL_W-1:0]   r_mul;
    logic signed [15:0]        r_wrd;
    logic [15:0]               r_weight_mem [MAX_INPUTS];
    logic                      r_res_vld;
    t_result_item              r_res;

    logic signed [31:0]        w_ma;
    logic signed [DER_W-1:0]   w_mb;
    logic signed [ACC_W:0]     w_acc_sum;
    logic signed [WIDE_W-1:0]  w_mul_rnd;
    logic signed [WIDE_W-1:0]  w_upd_sum;
    logic [TMP_W-1:0]          w_abs;
    logic [TANH_IDX_W-1:0]     w_lut_idx;
    logic [15:0]               w_tanh;
    logic [16:0]               w_res;
    logic                      w_mem_we;
    logic [15:0]               w_mem_wd;
    logic [IDX_W-1:0]          w_addr;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_addr   = r_cmd.index[IDX_W-1:0];
    assign pready   = 1'b1;

    nbu_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .i_last   (r_cmd.last),
        .o_busy   (busy),
        .o_uword  (w_uw)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_RATE: r_rate <= pwdata[12:0];
                REG_MODE: r_mode <= pwdata[0];
                default:  r_rate <= r_rate;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RATE: prdata = {19'd0, r_rate};
            REG_MODE: prdata = {31'd0, r_mode};
            default:  prdata = '0;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (w_uw.mul_a)
            MA_VAL:  w_ma = 32'(r_cmd.value);
            MA_TMP:  w_ma = 32'(r_tmp);
            MA_OUT:  w_ma = 32'(r_out);
            MA_DIFF: w_ma = 32'(r_cmd.value) - 32'(r_out);
            MA_PROD: w_ma = signed'(r_mul[31:0]);
            default: w_ma = '0;
        endcase
        case (w_uw.mul_b)
            MB_WRD:  w_mb = DER_W'(r_wrd);
            MB_OW:   w_mb = DER_W'(r_cmd.outgoing_weight);
            MB_LEAK: w_mb = LEAK_Q;
            MB_OUT:  w_mb = DER_W'(r_out);
            MB_DER:  w_mb = r_der;
            MB_GRAD: w_mb = DER_W'(r_grad);
            MB_RATE: w_mb = signed'({7'd0, r_rate});
            default: w_mb = '0;
        endcase
    end

    assign w_acc_sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(signed'(r_mul[31:0]));
    assign w_mul_rnd = rnd(WIDE_W'(r_mul), FRAC_BITS);
    assign w_upd_sum = rnd(WIDE_W'(r_mul), UPD_SHIFT) + WIDE_W'(r_wrd);

    // tanh lookup on |s|, clamped to one beyond 4.0
    assign w_abs     = r_tmp[TMP_W-1] ? TMP_W'(-r_tmp) : TMP_W'(r_tmp);
    assign w_lut_idx = TANH_IDX_W'((40'(w_abs) * TANH_DEPTH) >> (FRAC_BITS + 2));
    always_comb begin
        if (w_abs >= TMP_W'(4 << FRAC_BITS)) begin
            w_tanh = 16'(1 << FRAC_BITS);
        end else begin
            w_tanh = TANH_LUT[w_lut_idx];
        end
        if (r_tmp[TMP_W-1]) begin
            w_tanh = -w_tanh;
        end
    end

    always_comb begin
        case (w_uw.emit)
            EM_FWD: begin
                if (!r_mode) begin
                    w_res = {1'b0, w_tanh};
                end else if (r_tmp > TMP_W'(0)) begin
                    w_res = sat16(WIDE_W'(r_tmp));
                end else begin
                    w_res = sat16(w_mul_rnd);
                end
            end
            EM_OGRAD: begin
                if (r_mode) begin
                    w_res = sat16((WIDE_W'(r_out) - WIDE_W'(r_cmd.value)) <<< 1);
                end else begin
                    w_res = sat16(w_mul_rnd);
                end
            end
            EM_HGRAD: w_res = sat16(w_mul_rnd);
            EM_UPD:   w_res = sat16(w_upd_sum);
            default:  w_res = '0;
        endcase
    end

    assign w_mem_we = w_uw.mem_wr || (w_uw.emit == EM_UPD);
    assign w_mem_wd = w_uw.mem_wr ? r_cmd.value : w_res[15:0];

    // weight memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_weight_mem[w_addr] <= w_mem_wd;
        end
        r_wrd <= r_weight_mem[w_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        if (w_uw.mul_en) begin
            r_mul <= w_ma * w_mb;
        end
        if (w_uw.acc_round) begin
            r_tmp <= TMP_W'(rnd(WIDE_W'(r_acc), FRAC_BITS));
        end
        if (w_uw.der_load) begin
            if (r_mode) begin
                r_der <= (r_out > 16'sd0) ? ONE_Q : LEAK_Q;
            end else begin
                r_der <= DER_W'(WIDE_W'(ONE_Q) - w_mul_rnd);
            end
        end
        if (w_uw.emit != EM_NONE) begin
            r_res.kind         <= r_cmd.opcode;
            r_res.result_value <= w_res[15:0];
            r_res.saturated    <= w_res[16];
        end
    end

    // neuron state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_out     <= '0;
            r_grad    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= (w_uw.emit != EM_NONE);
            if (w_uw.acc_add) begin
                if (w_acc_sum > ACC_MAX) begin
                    r_acc <= ACC_W'(ACC_MAX);
                end else if (w_acc_sum < ACC_MIN) begin
                    r_acc <= ACC_W'(ACC_MIN);
                end else begin
                    r_acc <= ACC_W'(w_acc_sum);
                end
            end else if (w_uw.acc_round) begin
                r_acc <= '0;
            end
            if (w_uw.emit == EM_FWD) begin
                r_out <= w_res[15:0];
            end
            if (w_uw.emit == EM_OGRAD || w_uw.emit == EM_HGRAD) begin
                r_grad <= w_res[15:0];
            end
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule

`default_nettype wire

@@ design/nbu_chk.sv @@
// Port-level checker for the neuron backprop unit, bound to the top level.
`default_nettype none

module nbu_chk (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire nbu_pkg::t_cmd_item      i_cmd,
    input  wire logic                    o_result_valid,
    input  wire nbu_pkg::t_result_item   o_result
);
    import nbu_pkg::*;

    // a result word lands only after the command has finished
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result word while busy");

    // no command is short enough to give results in back-to-back cycles
    a_res_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result words in consecutive cycles");

    // weight write takes one step and gives no result
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == OP_WRITE) |=> busy ##1 (!busy && !o_result_valid))
        else $error("weight write misbehaved");

    // unused opcodes are dropped
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode > OP_UPDATE) |=> (!busy && !o_result_valid))
        else $error("unused opcode not dropped");

endmodule

bind neuron_backprop_unit nbu_chk u_nbu_chk (.*);

`default_nettype wire

@@ test/neuron_backprop_unit_test.sv @@
// Self-checking testbench for the neuron backprop unit: commands, register port, predictor.
module neuron_backprop_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nbu_pkg::*;

    typedef longint unsigned u64_t;

    localparam int     TABLE_DEPTH   = TANH_DEPTH;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     CLAMP_RUN     = 520;
    localparam int     PHASE_WORDS   = 65;
    localparam int     PHASES        = 6;
    localparam int     RATE_TOP      = 4096;
    localparam u64_t   ONE_Q30       = u64_t'(1) << 30;
    localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
    localparam longint LEAK_Q        = ((longint'(1) << FRAC_BITS) + 5) / 10;
    localparam longint ACC_HI        = (longint'(1) << 39) - 1;
    localparam longint ACC_LO        = -(longint'(1) << 39);
    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;
    localparam logic [2:0] OP_SPARE = 3'd7;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_cmd_item     i_cmd;
    logic          o_result_valid;
    t_result_item  o_result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    neuron_backprop_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // predicted neuron state
    logic signed [15:0] tanh_ref [TABLE_DEPTH];
    logic signed [15:0] neuron_weights [MAX_INPUTS];
    bit                 weight_written [MAX_INPUTS];
    longint             neuron_acc  = 0;
    longint             neuron_out  = 0;
    longint             neuron_grad = 0;
    logic [12:0]        rate_q12    = RATE_RESET;
    logic               leaky_on    = 1'b0;

    t_result_item pending_results [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           words_sent     = 0;
    bit           gaps_on        = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("neuron_backprop_unit_test: errors");
            $finish;
        end
    end

    // tanh(4i/depth) rounded to Q3.12, exp(-2x) from a Taylor series and four squarings
    function automatic logic signed [15:0] tanh_point(input int i);
        u64_t z;
        u64_t term;
        u64_t sum;
        u64_t num;
        u64_t den;
        z    = (u64_t'(i) << 29) / u64_t'(TABLE_DEPTH);
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * z) >> 30) / u64_t'(k);
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 4; k++)
            sum = (sum * sum) >> 30;
        num = (ONE_Q30 - sum) << (FRAC_BITS + 1);
        den = u64_t'(2) * (ONE_Q30 + sum);
        return 16'((num + ONE_Q30 + sum) / den);
    endfunction

    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint acc_clamp(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic logic signed [15:0] clamp_q(input longint v, inout logic sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return 16'(v);
    endfunction

    function automatic longint tanh_q(input longint s);
        longint a;
        longint r;
        a = (s < 0) ? -s : s;
        if (a >= 4 * ONE_Q) begin
            r = ONE_Q;
        end else begin
            r = tanh_ref[(a * TABLE_DEPTH) >>> (FRAC_BITS + 2)];
        end
        return (s < 0) ? -r : r;
    endfunction

    function automatic longint slope_q();
        if (leaky_on) return (neuron_out > 0) ? ONE_Q : LEAK_Q;
        return ONE_Q - round_shift(neuron_out * neuron_out, FRAC_BITS);
    endfunction

    // advance the predicted neuron by one command word; 1 when it yields a result
    function automatic bit neuron_step(input t_cmd_item w, output t_result_item r);
        longint val;
        longint s;
        logic   sat;
        logic signed [15:0] q;
        val = longint'($signed(w.value));
        sat = 1'b0;
        case (w.opcode)
            OP_WRITE: begin
                neuron_weights[w.index] = w.value;
                weight_written[w.index] = 1'b1;
                return 1'b0;
            end
            OP_FWD: begin
                neuron_acc = acc_clamp(neuron_acc + val * longint'(neuron_weights[w.index]));
                if (!w.last) return 1'b0;
                s = round_shift(neuron_acc, FRAC_BITS);
                neuron_acc = 0;
                if (leaky_on) begin
                    if (s <= 0) s = round_shift(s * LEAK_Q, FRAC_BITS);
                    q = clamp_q(s, sat);
                end else begin
                    q = 16'(tanh_q(s));
                end
                neuron_out = longint'(q);
            end
            OP_OGRAD: begin
                if (leaky_on) begin
                    s = 2 * (neuron_out - val);
                end else begin
                    s = round_shift((val - neuron_out) * slope_q(), FRAC_BITS);
                end
                q = clamp_q(s, sat);
                neuron_grad = longint'(q);
            end
            OP_HGRAD: begin
                neuron_acc = acc_clamp(neuron_acc + val * longint'($signed(w.outgoing_weight)));
                if (!w.last) return 1'b0;
                s = round_shift(neuron_acc, FRAC_BITS);
                neuron_acc = 0;
                q = clamp_q(round_shift(s * slope_q(), FRAC_BITS), sat);
                neuron_grad = longint'(q);
            end
            OP_UPDATE: begin
                s = round_shift(val * neuron_grad * longint'(rate_q12),
                                2 * FRAC_BITS + RATE_FRAC);
                q = clamp_q(longint'(neuron_weights[w.index]) + s, sat);
                neuron_weights[w.index] = q;
            end
            default: return 1'b0;
        endcase
        r.kind         = w.opcode;
        r.result_value = q;
        r.saturated    = sat;
        return 1'b1;
    endfunction

    function automatic t_cmd_item make_word(input logic [2:0] op, input logic [7:0] idx,
                                            input logic signed [15:0] val,
                                            input logic signed [15:0] ow, input logic lst);
        t_cmd_item w;
        w.opcode          = op;
        w.index           = idx;
        w.value           = val;
        w.outgoing_weight = ow;
        w.last            = lst;
        return w;
    endfunction

    // a mix of values near the working range, extremes and full-range noise
    function automatic logic signed [15:0] rand_q();
        int v;
        v = int'($urandom_range(0, 32'(2 * ONE_Q))) - int'(ONE_Q);
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3, 4: return 16'($urandom);
            default: return 16'(v);
        endcase
    endfunction

    function automatic logic [7:0] pick_written_index();
        logic [7:0] i;
        i = 8'($urandom);
        while (!weight_written[i])
            i = 8'($urandom);
        return i;
    endfunction

    always @(posedge i_clk) begin
        t_result_item want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: kind %0d value %0d sat %0b",
                         $time, o_result.kind, $signed(o_result.result_value),
                         o_result.saturated);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.kind !== want.kind) begin
                    $display("%0t: kind expected %0d, got %0d",
                             $time, want.kind, o_result.kind);
                    mismatch_count++;
                end
                if (o_result.result_value !== want.result_value) begin
                    $display("%0t: result_value expected %0d, got %0d", $time,
                             $signed(want.result_value), $signed(o_result.result_value));
                    mismatch_count++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, want.saturated, o_result.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic issue_word(input t_cmd_item w);
        t_result_item r;
        start = 1'b1;
        i_cmd = w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (neuron_step(w, r))
            pending_results.push_back(r);
        if (w.opcode <= OP_UPDATE)
            words_sent++;
        @(negedge i_clk);
        start = 1'b0;
        if (gaps_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
    endtask

    task automatic drain_results(input int settle);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic reg_sel);
        logic [31:0] got;
        logic [31:0] want;
        apb_transfer(1'b0, {reg_sel, 2'b00}, 32'd0, got);
        want = (reg_sel == REG_RATE) ? 32'(rate_q12) : 32'(leaky_on);
        if (got !== want) begin
            $display("%0t: register %0d readback expected %0d, got %0d",
                     $time, reg_sel, want, got);
            mismatch_count++;
        end
    endtask

    // hold until the unit is idle, then write and read back
    task automatic set_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] unused_rd;
        drain_results(SETTLE_CYCLES);
        apb_transfer(1'b1, {reg_sel, 2'b00}, value, unused_rd);
        if (reg_sel == REG_RATE) begin
            rate_q12 = value[12:0];
        end else begin
            leaky_on = value[0];
        end
        check_register(reg_sel);
    endtask

    task automatic test_reset_values();
        check_register(REG_RATE);
        check_register(REG_MODE);
    endtask

    task automatic test_directed_ops();
        issue_word(make_word(OP_WRITE, 8'd0,   Q_MAX,    Q_MIN, 1'b1));
        issue_word(make_word(OP_WRITE, 8'd255, Q_MIN,    Q_MAX, 1'b0));
        issue_word(make_word(OP_WRITE, 8'd170, 16'sd1024, 16'sd0, 1'b0));
        for (int m = 0; m < 2; m++) begin
            set_register(REG_MODE, 32'(m));
            // large positive sum, then extreme targets
            issue_word(make_word(OP_FWD,    8'd0,   Q_MAX, 16'sd0, 1'b0));
            issue_word(make_word(OP_FWD,    8'd255, Q_MIN, 16'sd0, 1'b1));
            issue_word(make_word(OP_OGRAD,  8'd85,  Q_MIN, Q_MAX,  1'b1));
            issue_word(make_word(OP_FWD,    8'd170, 16'sd2048, Q_MIN, 1'b1));
            issue_word(make_word(OP_FWD,    8'd255, Q_MAX, 16'sd0, 1'b1));
            issue_word(make_word(OP_OGRAD,  8'd0,   Q_MAX, 16'sd0, 1'b0));
            // hidden and forward elements share one accumulator
            issue_word(make_word(OP_HGRAD,  8'd255, Q_MIN, Q_MIN,  1'b0));
            issue_word(make_word(OP_FWD,    8'd170, 16'sd4096, 16'sd0, 1'b0));
            issue_word(make_word(OP_HGRAD,  8'd0,   Q_MAX, Q_MIN,  1'b1));
            issue_word(make_word(OP_UPDATE, 8'd0,   Q_MAX, Q_MAX,  1'b0));
            issue_word(make_word(OP_UPDATE, 8'd255, Q_MIN, Q_MIN,  1'b1));
            issue_word(make_word(OP_SPARE,  8'd255, Q_MIN, Q_MAX,  1'b1));
        end
    endtask

    // enough extreme products to pin the accumulator at its upper rail
    task automatic test_accumulator_clamp();
        set_register(REG_MODE, 32'd0);
        for (int k = 0; k < CLAMP_RUN; k++)
            issue_word(make_word(OP_HGRAD, 8'($urandom), Q_MIN, Q_MIN,
                                 k == CLAMP_RUN - 1));
    endtask

    task automatic send_noise_word();
        logic [2:0] op;
        logic [7:0] idx;
        op  = 3'($urandom);
        idx = 8'($urandom);
        if ((op == OP_FWD || op == OP_UPDATE) && !weight_written[idx])
            idx = pick_written_index();
        issue_word(make_word(op, idx, rand_q(), rand_q(), 1'($urandom)));
    endtask

    task automatic run_training_step();
        int n;
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                issue_word(make_word(OP_WRITE, 8'($urandom), rand_q(), rand_q(),
                                     1'($urandom)));
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            issue_word(make_word(OP_FWD, pick_written_index(), rand_q(), rand_q(), k == n - 1));
        if ($urandom_range(0, 1) == 0) begin
            issue_word(make_word(OP_OGRAD, 8'($urandom), rand_q(), rand_q(), 1'($urandom)));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                issue_word(make_word(OP_HGRAD, 8'($urandom), rand_q(), rand_q(), k == n - 1));
        end
        // stall the sender until the unit has delivered everything
        if ($urandom_range(0, 15) == 0)
            drain_results(0);
        repeat ($urandom_range(1, 3))
            issue_word(make_word(OP_UPDATE, pick_written_index(), rand_q(), rand_q(),
                                 1'($urandom)));
    endtask

    task automatic test_random_training();
        logic [31:0] rate;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       rate = 32'd0;
                1:       rate = 32'(RATE_TOP);
                default: rate = 32'($urandom_range(0, RATE_TOP));
            endcase
            set_register(REG_RATE, rate);
            set_register(REG_MODE, 32'(p % 2));
            gaps_on    = (p != PHASES - 1);
            words_sent = 0;
            while (words_sent < PHASE_WORDS) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_noise_word();
                end else begin
                    run_training_step();
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tanh_ref[i] = tanh_point(i);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_values();
        test_directed_ops();
        test_accumulator_clamp();
        test_random_training();
        drain_results(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("neuron_backprop_unit_test: clean");
        end else begin
            $display("neuron_backprop_unit_test: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/nbu_pkg.sv
design/nbu_seq.sv
design/neuron_backprop_unit.sv
design/nbu_chk.sv
test/neuron_backprop_unit_test.sv
